[design/tsrm_pkg.sv]
package tsrm_pkg;

    localparam int ROW_COUNT_DEF  = 64;
    localparam int TOKEN_BITS_DEF = 16;

    localparam int KIND_W  = 2;
    localparam int ROW_W   = 6;
    localparam int TOK_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int RES_W   = 2;

    localparam logic [KIND_W-1:0] KIND_BEGIN    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMMIT   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EVALUATE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_END_TOKEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_TS_TOKEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_TS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INIT_TS = 3'd4;

    typedef struct packed {
        logic             take;
        logic             append_wr;
        logic             load_hist;
        logic             emit;
        logic [RES_W-1:0] k;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              pair_ok;
        logic              out_free;
        logic [RES_W-1:0]  last_idx;
    } status_t;

endpackage

[design/timestamp_token_rule_masker_core.sv]
// Timestamp token rule masker. Items arrive on the input channel (in_valid, in_stall)
// as begin, append, commit or evaluate requests for a decoding row. Begin and commit
// items produce nothing. An append item with both rows in range first reads the
// parent row's current history copy from the history RAM and then writes the
// extended copy into the row's pending slot. An evaluate item reads the row's
// history from the RAM into a history register, then emits one to three
// suppression ranges on the output channel (out_valid, out_stall), one per cycle
// while the receiver does not stall.
// The final result of an evaluate item carries last_range.
// While the receiver stalls, the output register holds its item and the emit sequence
// waits; a new input item is accepted as soon as the last result has been loaded.
// Configuration registers are written through cfg_we, cfg_index and cfg_data.
// Reset clears the configuration registers, the copy selections and the pending
// flags; a row's history is undefined until a begin item has been sent for it.
module timestamp_token_rule_masker_core #(
    parameter int ROW_COUNT  = tsrm_pkg::ROW_COUNT_DEF,
    parameter int TOKEN_BITS = tsrm_pkg::TOKEN_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsrm_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tsrm_pkg::KIND_W-1:0]     kind,
    input  logic [tsrm_pkg::ROW_W-1:0]      row,
    input  logic [tsrm_pkg::ROW_W-1:0]      parent_row,
    input  logic [tsrm_pkg::TOK_W-1:0]      token,
    input  logic                            timestamps_enabled,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tsrm_pkg::ROW_W-1:0]      out_row,
    output logic [tsrm_pkg::TOK_W-1:0]      range_low,
    output logic [tsrm_pkg::TOK_W-1:0]      range_high,
    output logic                            range_valid,
    output logic                            needs_probability_check,
    output logic                            last_range
);
    import tsrm_pkg::*;

    cmd_t    cmd;
    status_t status;

    tsrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tsrm_datapath #(
        .ROW_COUNT  (ROW_COUNT),
        .TOKEN_BITS (TOKEN_BITS)
    ) u_datapath (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cfg_we                  (cfg_we),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data),
        .kind                    (kind),
        .row                     (row),
        .parent_row              (parent_row),
        .token                   (token),
        .timestamps_enabled      (timestamps_enabled),
        .out_stall               (out_stall),
        .out_valid               (out_valid),
        .out_row                 (out_row),
        .range_low               (range_low),
        .range_high              (range_high),
        .range_valid             (range_valid),
        .needs_probability_check (needs_probability_check),
        .last_range              (last_range),
        .cmd                     (cmd),
        .status                  (status)
    );

endmodule

[design/tsrm_ram.sv]
module tsrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[design/tsrm_ctrl.sv]
module tsrm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  tsrm_pkg::status_t status,
    output tsrm_pkg::cmd_t    cmd
);
    import tsrm_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_APPEND = 2'd1;
    localparam logic [1:0] S_EVLOAD = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [RES_W-1:0] k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        cmd           = '0;
        cmd.k         = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.kind == KIND_APPEND && status.pair_ok)
                    begin
                        state_next = S_APPEND;
                    end
                    else if (status.kind == KIND_EVALUATE)
                    begin
                        state_next = S_EVLOAD;
                    end
                end
            end
            S_APPEND:
            begin
                cmd.append_wr = 1'b1;
                state_next    = S_IDLE;
            end
            S_EVLOAD:
            begin
                cmd.load_hist = 1'b1;
                k_next        = '0;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (k_reg == status.last_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/tsrm_datapath.sv]
module tsrm_datapath #(
    parameter int ROW_COUNT  = tsrm_pkg::ROW_COUNT_DEF,
    parameter int TOKEN_BITS = tsrm_pkg::TOKEN_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsrm_pkg::CFG_W-1:0]      cfg_data,
    input  logic [tsrm_pkg::KIND_W-1:0]     kind,
    input  logic [tsrm_pkg::ROW_W-1:0]      row,
    input  logic [tsrm_pkg::ROW_W-1:0]      parent_row,
    input  logic [tsrm_pkg::TOK_W-1:0]      token,
    input  logic                            timestamps_enabled,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [tsrm_pkg::ROW_W-1:0]      out_row,
    output logic [tsrm_pkg::TOK_W-1:0]      range_low,
    output logic [tsrm_pkg::TOK_W-1:0]      range_high,
    output logic                            range_valid,
    output logic                            needs_probability_check,
    output logic                            last_range,
    input  tsrm_pkg::cmd_t                  cmd,
    output tsrm_pkg::status_t               status
);
    import tsrm_pkg::*;

    localparam int RIW   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int DEPTH = 2 * ROW_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int TB    = TOKEN_BITS;
    localparam int EW    = 3 * TB + 3;
    localparam int O_PREV = TB;
    localparam int O_TS   = 2 * TB;
    localparam int O_SEEN = 3 * TB;
    localparam int O_NE   = 3 * TB + 1;
    localparam int O_EN   = 3 * TB + 2;

    logic [CFG_W-1:0] end_id_reg, no_ts_id_reg, first_ts_reg, last_ts_reg, max_init_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_id_reg   <= '0;
            no_ts_id_reg <= '0;
            first_ts_reg <= '0;
            last_ts_reg  <= '0;
            max_init_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_END_TOKEN:   end_id_reg   <= cfg_data;
                CFG_NO_TS_TOKEN: no_ts_id_reg <= cfg_data;
                CFG_FIRST_TS:    first_ts_reg <= cfg_data;
                CFG_LAST_TS:     last_ts_reg  <= cfg_data;
                CFG_MAX_INIT_TS: max_init_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    logic [31:0]    row32, parent32, tok32;
    logic [RIW-1:0] in_idx, parent_idx, row_idx_reg;
    logic           in_row_ok, in_parent_ok;
    logic [TB-1:0]  in_tok;

    assign row32        = {26'd0, row};
    assign parent32     = {26'd0, parent_row};
    assign tok32        = {16'd0, token};
    assign in_idx       = row32[RIW-1:0];
    assign parent_idx   = parent32[RIW-1:0];
    assign in_tok       = tok32[TB-1:0];
    assign in_row_ok    = row32 < 32'(ROW_COUNT);
    assign in_parent_ok = parent32 < 32'(ROW_COUNT);

    logic [ROW_W-1:0] row_reg;
    logic             row_ok_reg;
    logic [TB-1:0]    tok_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            row_reg     <= row;
            row_ok_reg  <= in_row_ok;
            row_idx_reg <= in_idx;
            tok_reg     <= in_tok;
        end
    end

    logic [ROW_COUNT-1:0] sel_reg, pend_reg;
    logic                 do_begin, do_commit;

    assign do_begin  = cmd.take && kind == KIND_BEGIN && in_row_ok;
    assign do_commit = cmd.take && kind == KIND_COMMIT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg  <= '0;
            pend_reg <= '0;
        end
        else if (do_commit)
        begin
            sel_reg  <= sel_reg ^ pend_reg;
            pend_reg <= '0;
        end
        else if (do_begin)
        begin
            pend_reg[in_idx] <= 1'b0;
        end
        else if (cmd.append_wr)
        begin
            pend_reg[row_idx_reg] <= 1'b1;
        end
    end

    logic [RIW:0]   raddr_full, waddr_full;
    logic [EW-1:0]  wdata, rdata, dst, hist_reg;
    logic           mem_we;

    assign raddr_full = (kind == KIND_APPEND) ? {parent_idx, sel_reg[parent_idx]}
                                              : {in_idx, sel_reg[in_idx]};

    always_comb
    begin
        dst          = rdata;
        dst[TB-1:0]  = tok_reg;
        dst[O_PREV +: TB] = rdata[O_NE] ? rdata[TB-1:0] : tok_reg;
        dst[O_NE]    = 1'b1;
        if (32'(tok_reg) >= 32'(first_ts_reg))
        begin
            dst[O_TS +: TB] = tok_reg;
            dst[O_SEEN]     = 1'b1;
        end
    end

    always_comb
    begin
        if (cmd.append_wr)
        begin
            waddr_full = {row_idx_reg, ~sel_reg[row_idx_reg]};
            wdata      = dst;
        end
        else
        begin
            waddr_full   = {in_idx, sel_reg[in_idx]};
            wdata        = '0;
            wdata[O_EN]  = timestamps_enabled;
        end
    end

    assign mem_we = do_begin || cmd.append_wr;

    tsrm_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr_full[AW-1:0]),
        .wdata (wdata),
        .raddr (raddr_full[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_hist)
        begin
            hist_reg <= rdata;
        end
    end

    logic [31:0] fb32, lt32, mi32, end32, last32, prev32, ts32;
    logic [31:0] fb_m1, end_m1, last_m1, mi_p1;

    assign fb32    = 32'(first_ts_reg);
    assign lt32    = 32'(last_ts_reg);
    assign mi32    = 32'(max_init_reg);
    assign end32   = 32'(end_id_reg);
    assign last32  = 32'(hist_reg[TB-1:0]);
    assign prev32  = 32'(hist_reg[O_PREV +: TB]);
    assign ts32    = 32'(hist_reg[O_TS +: TB]);
    assign fb_m1   = fb32 - 32'd1;
    assign end_m1  = end32 - 32'd1;
    assign last_m1 = last32 - 32'd1;
    assign mi_p1   = mi32 + 32'd1;

    logic             res_ok, res_chk;
    logic [TOK_W-1:0] res_lo, res_hi;
    logic [RES_W-1:0] last_idx;

    always_comb
    begin
        res_ok   = 1'b0;
        res_lo   = '0;
        res_hi   = '0;
        res_chk  = 1'b0;
        last_idx = 2'd0;
        if (row_ok_reg && hist_reg[O_EN])
        begin
            if (cmd.k == 2'd0)
            begin
                res_ok = 1'b1;
                res_lo = no_ts_id_reg;
                res_hi = no_ts_id_reg;
            end
            if (!hist_reg[O_NE])
            begin
                last_idx = 2'd2;
                if (cmd.k == 2'd1)
                begin
                    res_ok = fb32 != 32'd0;
                    res_lo = '0;
                    res_hi = fb_m1[TOK_W-1:0];
                end
                else if (cmd.k == 2'd2)
                begin
                    res_ok = mi32 < lt32;
                    res_lo = mi_p1[TOK_W-1:0];
                    res_hi = last_ts_reg;
                end
            end
            else if (last32 >= fb32)
            begin
                if (prev32 >= fb32)
                begin
                    last_idx = 2'd1;
                    if (cmd.k == 2'd1)
                    begin
                        res_ok = fb32 <= lt32;
                        res_lo = first_ts_reg;
                        res_hi = last_ts_reg;
                    end
                end
                else
                begin
                    last_idx = 2'd2;
                    res_chk  = 1'b1;
                    if (cmd.k == 2'd1)
                    begin
                        res_ok = end32 != 32'd0;
                        res_lo = '0;
                        res_hi = end_m1[TOK_W-1:0];
                    end
                    else if (cmd.k == 2'd2)
                    begin
                        res_ok = last32 > fb32;
                        res_lo = first_ts_reg;
                        res_hi = last_m1[TOK_W-1:0];
                    end
                end
            end
            else
            begin
                last_idx = 2'd1;
                res_chk  = 1'b1;
                if (cmd.k == 2'd1)
                begin
                    res_ok = hist_reg[O_SEEN] && ts32 >= fb32;
                    res_lo = first_ts_reg;
                    res_hi = ts32[TOK_W-1:0];
                end
            end
        end
    end

    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row                 <= row_reg;
            range_valid             <= res_ok;
            range_low               <= res_ok ? res_lo : '0;
            range_high              <= res_ok ? res_hi : '0;
            last_range              <= cmd.k == last_idx;
            needs_probability_check <= res_chk && cmd.k == last_idx;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.kind     = kind;
    assign status.pair_ok  = in_row_ok && in_parent_ok;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign status.last_idx = last_idx;

endmodule
